/* hdl/mct_pkg.sv */
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types and codes of the MMC card state tracker: channel payloads,
// card state codes, event bit positions and the classified queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package mct_pkg;

    // Card state codes, as carried on the result channel
    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_READY = 4'd1,
        ST_IDENT = 4'd2,
        ST_STBY  = 4'd3,
        ST_TRAN  = 4'd4,
        ST_DATA  = 4'd5,
        ST_RCV   = 4'd6,
        ST_PRG   = 4'd7,
        ST_DIS   = 4'd8,
        ST_BTST  = 4'd9,
        ST_IRQ   = 4'd10,
        ST_INA   = 4'd15
    } card_state_t;

    // Event bit positions
    localparam int EV_PWR   = 0;
    localparam int EV_OK    = 1;
    localparam int EV_FAIL  = 2;
    localparam int EV_NOIRQ = 3;
    localparam int EV_CIRQ  = 4;
    localparam int EV_DONE  = 5;
    localparam int EV_TEND  = 6;

    // Error code that sends an idle card to ina
    localparam logic [2:0] ERR_NONCOMPAT_VOLT = 3'd3;

    typedef struct packed {
        logic [6:0] new_events;
        logic [5:0] cmd_index;
        logic       gen_read;
        logic [2:0] err_code;
    } item_t;

    typedef struct packed {
        logic [3:0] card_state;
        logic [6:0] events_left;
        logic       state_changed;
    } result_t;

    // Command decoded into the classes the state tables look at
    typedef struct packed {
        logic        c0;        // go idle
        logic        c1;        // send op cond
        logic        c2;        // all send cid
        logic        c3;        // set relative address
        logic        c7;        // select / deselect
        logic        c12;       // stop transmission
        logic        c14;       // bus test read
        logic        c15;       // go inactive
        logic        c40;       // go irq
        logic        c24_25;    // write block / multiple
        logic        pass;      // status or app command
        logic        tran_hit;  // command moves a tran card
        card_state_t tran_tgt;  // where it goes
    } cmd_class_t;

    typedef struct packed {
        logic [6:0] events;
        cmd_class_t cls;
        logic       err_ina;
    } entry_t;

endpackage

`default_nettype wire

/* hdl/mct_front.sv */
// ----------------------------------------------------------------------------
// mct_front
// Input side: takes event items, decodes the command index into command
// classes and hands the classified entry to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mct_front (
    input  wire mct_pkg::item_t  item,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire logic            q_full,
    output logic                 q_push,
    output mct_pkg::entry_t      q_entry
);
    import mct_pkg::*;

    cmd_class_t cls;
    logic [5:0] c;
    logic       rd;

    assign c  = item.cmd_index;
    assign rd = item.gen_read;

    always_comb
    begin
        cls          = '0;
        cls.tran_tgt = ST_TRAN;
        cls.c0       = (c == 6'd0);
        cls.c1       = (c == 6'd1);
        cls.c2       = (c == 6'd2);
        cls.c3       = (c == 6'd3);
        cls.c7       = (c == 6'd7);
        cls.c12      = (c == 6'd12);
        cls.c14      = (c == 6'd14);
        cls.c15      = (c == 6'd15);
        cls.c40      = (c == 6'd40);
        cls.c24_25   = (c == 6'd24) || (c == 6'd25);
        cls.pass     = (c == 6'd13) || (c == 6'd55);
        // Transfer-state table; command numbers are disjoint so at most one hits
        unique case (c)
            6'd7:
            begin
                cls.tran_hit = 1'b1;
                cls.tran_tgt = ST_STBY;
            end
            6'd19:
            begin
                cls.tran_hit = 1'b1;
                cls.tran_tgt = ST_BTST;
            end
            6'd6, 6'd28, 6'd29, 6'd38:
            begin
                cls.tran_hit = 1'b1;
                cls.tran_tgt = ST_PRG;
            end
            6'd8, 6'd11, 6'd17, 6'd18, 6'd30:
            begin
                cls.tran_hit = 1'b1;
                cls.tran_tgt = ST_DATA;
            end
            6'd20, 6'd24, 6'd25, 6'd26, 6'd27, 6'd42:
            begin
                cls.tran_hit = 1'b1;
                cls.tran_tgt = ST_RCV;
            end
            6'd56:
            begin
                cls.tran_hit = 1'b1;
                cls.tran_tgt = rd ? ST_DATA : ST_RCV;
            end
            default:
            begin
                cls.tran_hit = 1'b0;
            end
        endcase
    end

    assign item_stall      = q_full;
    assign q_push          = item_valid && !q_full;
    assign q_entry.events  = item.new_events;
    assign q_entry.cls     = cls;
    assign q_entry.err_ina = (item.err_code == ERR_NONCOMPAT_VOLT);

endmodule

`default_nettype wire

/* hdl/mct_queue.sv */
// ----------------------------------------------------------------------------
// mct_queue
// Short FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mct_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mct_pkg::entry_t wr_entry,
    input  wire logic            pop,
    output mct_pkg::entry_t      rd_entry,
    output logic                 full,
    output logic                 empty
);
    import mct_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/mct_back.sv */
// ----------------------------------------------------------------------------
// mct_back
// Execution side: holds card state and pending events, applies one rule per
// entry and registers the result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mct_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mct_pkg::entry_t q_entry,
    input  wire logic            q_empty,
    output logic                 q_pop,
    output mct_pkg::result_t     result,
    output logic                 result_valid,
    input  wire logic            result_stall
);
    import mct_pkg::*;

    card_state_t  state_reg;
    card_state_t  state_next;
    logic [6:0]   pend_reg;
    logic [6:0]   pend_next;
    logic         entered;
    logic         out_valid_reg;
    result_t      out_reg;
    cmd_class_t   k;
    logic         ok;
    logic         at_stby;

    // Advance whenever the output register is free or being taken
    assign q_pop   = !q_empty && (!out_valid_reg || !result_stall);
    assign k       = q_entry.cls;
    assign at_stby = (state_reg >= ST_STBY);

    always_comb
    begin
        pend_next  = pend_reg | q_entry.events;
        ok         = pend_next[EV_OK];
        state_next = state_reg;
        entered    = 1'b0;
        if (pend_next[EV_PWR])
        begin
            state_next         = ST_IDLE;
            entered            = 1'b1;
            pend_next[EV_PWR]  = 1'b0;
        end
        else if (ok && k.c15 && at_stby)
        begin
            state_next        = ST_INA;
            entered           = 1'b1;
            pend_next[EV_OK]  = 1'b0;
        end
        else if (ok && k.c0 && state_reg != ST_INA)
        begin
            state_next        = ST_IDLE;
            entered           = 1'b1;
            pend_next[EV_OK]  = 1'b0;
        end
        else if (ok && at_stby && k.pass)
        begin
            pend_next[EV_OK] = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (ok)
                    begin
                        if (k.c1)
                        begin
                            state_next = ST_READY;
                            entered    = 1'b1;
                        end
                        pend_next[EV_OK] = 1'b0;
                    end
                    if (pend_next[EV_FAIL])
                    begin
                        if (q_entry.err_ina)
                        begin
                            state_next = ST_INA;
                            entered    = 1'b1;
                        end
                        pend_next[EV_FAIL] = 1'b0;
                    end
                end
                ST_READY:
                begin
                    if (ok)
                    begin
                        if (k.c2)
                        begin
                            state_next = ST_IDENT;
                            entered    = 1'b1;
                        end
                        pend_next[EV_OK] = 1'b0;
                    end
                    pend_next[EV_FAIL] = 1'b0;
                end
                ST_IDENT:
                begin
                    if (ok)
                    begin
                        if (k.c3)
                        begin
                            state_next = ST_STBY;
                            entered    = 1'b1;
                        end
                        pend_next[EV_OK] = 1'b0;
                    end
                end
                ST_IRQ:
                begin
                    if (pend_next[EV_NOIRQ] || pend_next[EV_CIRQ])
                    begin
                        state_next = ST_STBY;
                        entered    = 1'b1;
                    end
                    pend_next[EV_NOIRQ] = 1'b0;
                    pend_next[EV_CIRQ]  = 1'b0;
                end
                ST_STBY:
                begin
                    if (ok)
                    begin
                        if (k.c7)
                        begin
                            state_next = ST_TRAN;
                            entered    = 1'b1;
                        end
                        if (k.c40)
                        begin
                            state_next = ST_IRQ;
                            entered    = 1'b1;
                        end
                        pend_next[EV_OK] = 1'b0;
                    end
                end
                ST_TRAN:
                begin
                    if (ok)
                    begin
                        if (k.tran_hit)
                        begin
                            state_next = k.tran_tgt;
                            entered    = 1'b1;
                        end
                        pend_next[EV_OK] = 1'b0;
                    end
                end
                ST_DATA:
                begin
                    if (ok)
                    begin
                        if (k.c7)
                        begin
                            state_next = ST_STBY;
                            entered    = 1'b1;
                        end
                        if (k.c12)
                        begin
                            state_next = ST_TRAN;
                            entered    = 1'b1;
                        end
                        pend_next[EV_OK] = 1'b0;
                    end
                    if (pend_next[EV_DONE])
                    begin
                        state_next         = ST_TRAN;
                        entered            = 1'b1;
                        pend_next[EV_DONE] = 1'b0;
                    end
                end
                ST_RCV:
                begin
                    if (ok)
                    begin
                        if (k.c12)
                        begin
                            state_next = ST_PRG;
                            entered    = 1'b1;
                        end
                        pend_next[EV_OK] = 1'b0;
                    end
                    if (pend_next[EV_TEND])
                    begin
                        state_next         = ST_PRG;
                        entered            = 1'b1;
                        pend_next[EV_TEND] = 1'b0;
                    end
                end
                ST_PRG:
                begin
                    if (ok)
                    begin
                        if (k.c7)
                        begin
                            state_next = ST_DIS;
                            entered    = 1'b1;
                        end
                        if (k.c24_25)
                        begin
                            state_next = ST_RCV;
                            entered    = 1'b1;
                        end
                        pend_next[EV_OK] = 1'b0;
                    end
                    if (pend_next[EV_DONE])
                    begin
                        state_next         = ST_TRAN;
                        entered            = 1'b1;
                        pend_next[EV_DONE] = 1'b0;
                    end
                end
                ST_DIS:
                begin
                    if (ok)
                    begin
                        if (k.c7)
                        begin
                            state_next = ST_PRG;
                            entered    = 1'b1;
                        end
                        pend_next[EV_OK] = 1'b0;
                    end
                    if (pend_next[EV_DONE])
                    begin
                        state_next         = ST_STBY;
                        entered            = 1'b1;
                        pend_next[EV_DONE] = 1'b0;
                    end
                end
                ST_BTST:
                begin
                    if (ok)
                    begin
                        if (k.c14)
                        begin
                            state_next = ST_TRAN;
                            entered    = 1'b1;
                        end
                        pend_next[EV_OK] = 1'b0;
                    end
                end
                default:
                begin
                    // ina: only the global rules apply
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                state_reg     <= state_next;
                pend_reg      <= pend_next;
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg.card_state    <= state_next;
            out_reg.events_left   <= pend_next;
            out_reg.state_changed <= entered;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    a_no_pwr_left: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg[EV_PWR])
        else $error("power_on left pending");

    a_state_reachable: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == 4'd11 || state_reg == 4'd12 ||
          state_reg == 4'd13 || state_reg == 4'd14))
        else $error("card state outside the reachable set");

    a_hold_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !entered) |=> (out_reg.card_state == $past(state_reg)))
        else $error("state moved without an entry");

    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (out_reg.card_state == state_reg && out_reg.events_left == pend_reg))
        else $error("result register out of step with state");

endmodule

`default_nettype wire

/* hdl/mmc_card_state_tracker.sv */
// ----------------------------------------------------------------------------
// mmc_card_state_tracker
// Follows the state of an MMC card from raised event bits and the command
// just issued; reports state, leftover pending events and state entry.
//
// Usage:
//   item / item_valid / item_stall carry one event item per transfer; it is
//   taken on a rising edge with item_valid high and item_stall low.
//   result / result_valid / result_stall carry one result per item, in order.
//   An accepted item is written into the classifier queue; the rule stage
//   then moves it into the output register that drives result_valid.
//   Throughput is one item per cycle while result_stall is low; the rule
//   stage updates the card state and pending mask once per entry.
//   While result_stall is high the result holds; the queue keeps taking
//   items until its QUEUE_DEPTH entries are used, then item_stall rises.
//   Reset puts the card in idle with nothing pending and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc_card_state_tracker #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mct_pkg::item_t   item,
    input  wire logic             item_valid,
    output logic                  item_stall,
    output mct_pkg::result_t      result,
    output logic                  result_valid,
    input  wire logic             result_stall
);
    import mct_pkg::*;

    entry_t push_entry;
    entry_t pop_entry;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;

    mct_front u_front (
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    mct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (push_entry),
        .pop      (q_pop),
        .rd_entry (pop_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    mct_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_entry      (pop_entry),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the MMC card state tracker. A queue of event items feeds a
// clocked driver; every accepted transfer runs through a card state tracker
// written in the bench, and a clocked monitor compares each result with the
// oldest predicted state. Directed walks through all card states come first,
// then random command sequences under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import mct_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 6;
    localparam int ITEMS_PER_PHASE = 375;
    localparam int TIMEOUT_CYCLES = 300000;

    // MMC command numbers the state tables look at
    localparam logic [5:0] CMD_GO_IDLE           = 6'd0;
    localparam logic [5:0] CMD_SEND_OP_COND      = 6'd1;
    localparam logic [5:0] CMD_ALL_SEND_CID      = 6'd2;
    localparam logic [5:0] CMD_SET_RCA           = 6'd3;
    localparam logic [5:0] CMD_SWITCH            = 6'd6;
    localparam logic [5:0] CMD_SELECT            = 6'd7;
    localparam logic [5:0] CMD_SEND_EXT_CSD      = 6'd8;
    localparam logic [5:0] CMD_READ_UNTIL_STOP   = 6'd11;
    localparam logic [5:0] CMD_STOP              = 6'd12;
    localparam logic [5:0] CMD_SEND_STATUS       = 6'd13;
    localparam logic [5:0] CMD_BUSTEST_R         = 6'd14;
    localparam logic [5:0] CMD_GO_INACTIVE       = 6'd15;
    localparam logic [5:0] CMD_READ_SINGLE       = 6'd17;
    localparam logic [5:0] CMD_READ_MULTI        = 6'd18;
    localparam logic [5:0] CMD_BUSTEST_W         = 6'd19;
    localparam logic [5:0] CMD_WRITE_UNTIL_STOP  = 6'd20;
    localparam logic [5:0] CMD_WRITE_BLOCK       = 6'd24;
    localparam logic [5:0] CMD_WRITE_MULTI       = 6'd25;
    localparam logic [5:0] CMD_PROGRAM_CID       = 6'd26;
    localparam logic [5:0] CMD_PROGRAM_CSD       = 6'd27;
    localparam logic [5:0] CMD_SET_WP            = 6'd28;
    localparam logic [5:0] CMD_CLR_WP            = 6'd29;
    localparam logic [5:0] CMD_SEND_WP           = 6'd30;
    localparam logic [5:0] CMD_ERASE             = 6'd38;
    localparam logic [5:0] CMD_GO_IRQ            = 6'd40;
    localparam logic [5:0] CMD_LOCK_UNLOCK       = 6'd42;
    localparam logic [5:0] CMD_APP               = 6'd55;
    localparam logic [5:0] CMD_GEN               = 6'd56;
    localparam logic [5:0] CMD_MAX               = 6'd63;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_MAX  = 3'd7;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    item_t   item = '0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    result_t result;
    logic    result_valid;
    logic    result_stall = 1'b0;

    item_t       pend_items[$];
    result_t     track_q[$];
    result_t     want;
    card_state_t card_now = ST_IDLE;
    logic [6:0]  events_held = '0;
    int          send_gap_pct = 38;
    int          recv_stall_pct = 66;
    int          errors = 0;

    // commands that keep a card moving through its states
    logic [5:0] flow_cmds[$] = '{
        CMD_SEND_OP_COND, CMD_ALL_SEND_CID, CMD_SET_RCA, CMD_SWITCH, CMD_SELECT,
        CMD_SEND_EXT_CSD, CMD_READ_UNTIL_STOP, CMD_STOP, CMD_SEND_STATUS,
        CMD_BUSTEST_R, CMD_READ_SINGLE, CMD_READ_MULTI, CMD_BUSTEST_W,
        CMD_WRITE_UNTIL_STOP, CMD_WRITE_BLOCK, CMD_WRITE_MULTI, CMD_PROGRAM_CID,
        CMD_PROGRAM_CSD, CMD_SET_WP, CMD_CLR_WP, CMD_SEND_WP, CMD_ERASE,
        CMD_GO_IRQ, CMD_LOCK_UNLOCK, CMD_APP, CMD_GEN
    };

    mmc_card_state_tracker uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [6:0] ev_bit(input int b);
        logic [6:0] m;
        m = '0;
        m[b] = 1'b1;
        return m;
    endfunction

    // Fold the new events into the held mask, apply one prioritized rule
    function automatic result_t track_step(input item_t it);
        logic [6:0]  f;
        logic [5:0]  c;
        logic        ok;
        logic        entered;
        logic        hit;
        card_state_t s;
        card_state_t nxt;
        card_state_t tgt;
        result_t     r;
        f = events_held | it.new_events;
        c = it.cmd_index;
        s = card_now;
        ok = f[EV_OK];
        nxt = s;
        tgt = s;
        entered = 1'b0;
        hit = 1'b0;
        if (f[EV_PWR]) begin
            nxt = ST_IDLE;
            entered = 1'b1;
            f[EV_PWR] = 1'b0;
        end else if (ok && c == CMD_GO_INACTIVE && s >= ST_STBY) begin
            nxt = ST_INA;
            entered = 1'b1;
            f[EV_OK] = 1'b0;
        end else if (ok && c == CMD_GO_IDLE && s != ST_INA) begin
            nxt = ST_IDLE;
            entered = 1'b1;
            f[EV_OK] = 1'b0;
        end else if (ok && s >= ST_STBY && (c == CMD_SEND_STATUS || c == CMD_APP)) begin
            f[EV_OK] = 1'b0;
        end else begin
            case (s)
                ST_IDLE:
                begin
                    if (ok) begin
                        if (c == CMD_SEND_OP_COND) begin
                            nxt = ST_READY;
                            entered = 1'b1;
                        end
                        f[EV_OK] = 1'b0;
                    end
                    if (f[EV_FAIL]) begin
                        if (it.err_code == ERR_NONCOMPAT_VOLT) begin
                            nxt = ST_INA;
                            entered = 1'b1;
                        end
                        f[EV_FAIL] = 1'b0;
                    end
                end
                ST_READY:
                begin
                    if (ok) begin
                        if (c == CMD_ALL_SEND_CID) begin
                            nxt = ST_IDENT;
                            entered = 1'b1;
                        end
                        f[EV_OK] = 1'b0;
                    end
                    f[EV_FAIL] = 1'b0;
                end
                ST_IDENT:
                begin
                    if (ok) begin
                        if (c == CMD_SET_RCA) begin
                            nxt = ST_STBY;
                            entered = 1'b1;
                        end
                        f[EV_OK] = 1'b0;
                    end
                end
                ST_IRQ:
                begin
                    if (f[EV_NOIRQ] || f[EV_CIRQ]) begin
                        nxt = ST_STBY;
                        entered = 1'b1;
                    end
                    f[EV_NOIRQ] = 1'b0;
                    f[EV_CIRQ] = 1'b0;
                end
                ST_STBY:
                begin
                    if (ok) begin
                        if (c == CMD_SELECT) begin
                            nxt = ST_TRAN;
                            entered = 1'b1;
                        end
                        if (c == CMD_GO_IRQ) begin
                            nxt = ST_IRQ;
                            entered = 1'b1;
                        end
                        f[EV_OK] = 1'b0;
                    end
                end
                ST_TRAN:
                begin
                    if (ok) begin
                        hit = 1'b1;
                        case (c)
                            CMD_SELECT: tgt = ST_STBY;
                            CMD_BUSTEST_W: tgt = ST_BTST;
                            CMD_SWITCH, CMD_SET_WP, CMD_CLR_WP, CMD_ERASE: tgt = ST_PRG;
                            CMD_SEND_EXT_CSD, CMD_READ_UNTIL_STOP, CMD_READ_SINGLE,
                            CMD_READ_MULTI, CMD_SEND_WP: tgt = ST_DATA;
                            CMD_WRITE_UNTIL_STOP, CMD_WRITE_BLOCK, CMD_WRITE_MULTI,
                            CMD_PROGRAM_CID, CMD_PROGRAM_CSD, CMD_LOCK_UNLOCK: tgt = ST_RCV;
                            CMD_GEN:
                            begin
                                if (it.gen_read)
                                    tgt = ST_DATA;
                                else
                                    tgt = ST_RCV;
                            end
                            default: hit = 1'b0;
                        endcase
                        if (hit) begin
                            nxt = tgt;
                            entered = 1'b1;
                        end
                        f[EV_OK] = 1'b0;
                    end
                end
                ST_DATA:
                begin
                    if (ok) begin
                        if (c == CMD_SELECT) begin
                            nxt = ST_STBY;
                            entered = 1'b1;
                        end
                        if (c == CMD_STOP) begin
                            nxt = ST_TRAN;
                            entered = 1'b1;
                        end
                        f[EV_OK] = 1'b0;
                    end
                    if (f[EV_DONE]) begin
                        nxt = ST_TRAN;
                        entered = 1'b1;
                        f[EV_DONE] = 1'b0;
                    end
                end
                ST_RCV:
                begin
                    if (ok) begin
                        if (c == CMD_STOP) begin
                            nxt = ST_PRG;
                            entered = 1'b1;
                        end
                        f[EV_OK] = 1'b0;
                    end
                    if (f[EV_TEND]) begin
                        nxt = ST_PRG;
                        entered = 1'b1;
                        f[EV_TEND] = 1'b0;
                    end
                end
                ST_PRG:
                begin
                    if (ok) begin
                        if (c == CMD_SELECT) begin
                            nxt = ST_DIS;
                            entered = 1'b1;
                        end
                        if (c == CMD_WRITE_BLOCK || c == CMD_WRITE_MULTI) begin
                            nxt = ST_RCV;
                            entered = 1'b1;
                        end
                        f[EV_OK] = 1'b0;
                    end
                    if (f[EV_DONE]) begin
                        nxt = ST_TRAN;
                        entered = 1'b1;
                        f[EV_DONE] = 1'b0;
                    end
                end
                ST_DIS:
                begin
                    if (ok) begin
                        if (c == CMD_SELECT) begin
                            nxt = ST_PRG;
                            entered = 1'b1;
                        end
                        f[EV_OK] = 1'b0;
                    end
                    if (f[EV_DONE]) begin
                        nxt = ST_STBY;
                        entered = 1'b1;
                        f[EV_DONE] = 1'b0;
                    end
                end
                ST_BTST:
                begin
                    if (ok) begin
                        if (c == CMD_BUSTEST_R) begin
                            nxt = ST_TRAN;
                            entered = 1'b1;
                        end
                        f[EV_OK] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        card_now = nxt;
        events_held = f;
        r.card_state = nxt;
        r.events_left = f;
        r.state_changed = entered;
        return r;
    endfunction

    task automatic add_item(input logic [6:0] ev, input logic [5:0] cmd,
                            input logic rd, input logic [2:0] err);
        item_t it;
        it.new_events = ev;
        it.cmd_index = cmd;
        it.gen_read = rd;
        it.err_code = err;
        pend_items.push_back(it);
    endtask

    // Mostly command successes on flow commands, with data and irq events mixed in
    function automatic item_t flow_item();
        item_t it;
        int    pick;
        pick = $urandom_range(99);
        it.cmd_index = flow_cmds[$urandom_range(flow_cmds.size() - 1)];
        it.gen_read = 1'($urandom_range(1));
        it.err_code = 3'($urandom_range(7));
        if (pick < 60)
            it.new_events = ev_bit(EV_OK);
        else if (pick < 70)
            it.new_events = ev_bit(EV_DONE);
        else if (pick < 78)
            it.new_events = ev_bit(EV_TEND);
        else if (pick < 84)
            it.new_events = ev_bit(EV_CIRQ);
        else if (pick < 88)
            it.new_events = ev_bit(EV_NOIRQ);
        else if (pick < 93)
            it.new_events = ev_bit(EV_FAIL);
        else
            it.new_events = 7'($urandom_range(127)) & ~ev_bit(EV_PWR);
        return it;
    endfunction

    task automatic fill_phase(input int n);
        int    added;
        int    kind;
        int    len;
        item_t it;
        added = 0;
        while (added < n) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                // power up and walk a card into tran
                add_item(ev_bit(EV_PWR), 6'($urandom_range(63)), 1'($urandom_range(1)),
                         3'($urandom_range(7)));
                add_item(ev_bit(EV_OK), CMD_SEND_OP_COND, 1'($urandom_range(1)), ERR_NONE);
                add_item(ev_bit(EV_OK), CMD_ALL_SEND_CID, 1'($urandom_range(1)), ERR_NONE);
                add_item(ev_bit(EV_OK), CMD_SET_RCA, 1'($urandom_range(1)), ERR_NONE);
                add_item(ev_bit(EV_OK), CMD_SELECT, 1'($urandom_range(1)), ERR_NONE);
                added += 5;
            end
            if (kind < 80) begin
                len = $urandom_range(12, 3);
                repeat (len) pend_items.push_back(flow_item());
                added += len;
            end else begin
                len = $urandom_range(4, 1);
                repeat (len) begin
                    it.new_events = 7'($urandom_range(127));
                    if ($urandom_range(3) != 0)
                        it.new_events[EV_PWR] = 1'b0;
                    it.cmd_index = 6'($urandom_range(63));
                    it.gen_read = 1'($urandom_range(1));
                    it.err_code = 3'($urandom_range(7));
                    pend_items.push_back(it);
                end
                added += len;
            end
        end
    endtask

    task automatic wait_drained();
        while (pend_items.size() != 0 || item_valid || track_q.size() != 0)
            @(posedge clk);
    endtask

    // Driver: hold the payload while stalled, advance on each transfer
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_valid <= 1'b0;
            item <= '0;
            card_now = ST_IDLE;
            events_held = '0;
        end else begin
            if (item_valid && !item_stall)
                track_q.push_back(track_step(item));
            if (!item_valid || !item_stall) begin
                if (pend_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    item <= pend_items.pop_front();
                    item_valid <= 1'b1;
                end else begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest predicted state
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_stall <= 1'b0;
        end else begin
            if (result_valid && !result_stall) begin
                if (track_q.size() == 0) begin
                    $error("result with no prediction waiting: state %0d", result.card_state);
                    errors++;
                end else begin
                    want = track_q.pop_front();
                    if (result.card_state !== want.card_state) begin
                        $error("card_state: expected %0d, actual %0d",
                               want.card_state, result.card_state);
                        errors++;
                    end
                    if (result.events_left !== want.events_left) begin
                        $error("events_left: expected 0x%02h, actual 0x%02h",
                               want.events_left, result.events_left);
                        errors++;
                    end
                    if (result.state_changed !== want.state_changed) begin
                        $error("state_changed: expected %0b, actual %0b",
                               want.state_changed, result.state_changed);
                        errors++;
                    end
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk through every card state
        add_item(7'd0, CMD_GO_IDLE, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_FAIL), CMD_SEND_OP_COND, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_SEND_OP_COND, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_FAIL), CMD_SEND_OP_COND, 1'b0, ERR_NONCOMPAT_VOLT);
        add_item(ev_bit(EV_OK), CMD_ALL_SEND_CID, 1'b0, ERR_NONE);
        // failure and no-irq in ident are not handled and stay pending
        add_item(ev_bit(EV_FAIL) | ev_bit(EV_NOIRQ), CMD_ALL_SEND_CID, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_SET_RCA, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_SEND_STATUS, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_SELECT, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_GEN, 1'b1, ERR_NONE);
        add_item(ev_bit(EV_DONE), CMD_GEN, 1'b1, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_GEN, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_TEND), CMD_GEN, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_SELECT, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_SELECT, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_DONE), CMD_SELECT, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_BUSTEST_W, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_BUSTEST_R, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_SELECT, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_GO_IRQ, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_CIRQ), CMD_GO_IRQ, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_GO_INACTIVE, 1'b0, ERR_NONE);
        // go-inactive again from ina re-enters ina; go-idle there is left pending
        add_item(ev_bit(EV_OK), CMD_GO_INACTIVE, 1'b0, ERR_NONE);
        add_item(ev_bit(EV_OK), CMD_GO_IDLE, 1'b0, ERR_NONE);
        add_item(7'h7f, CMD_MAX, 1'b1, ERR_MAX);
        add_item(ev_bit(EV_FAIL), CMD_MAX, 1'b0, ERR_NONCOMPAT_VOLT);

        // hold the sender until every predicted result is back
        wait_drained();

        fill_phase(ITEMS_PER_PHASE);
        wait_drained();

        send_gap_pct <= 66;
        recv_stall_pct <= 38;
        fill_phase(ITEMS_PER_PHASE);
        wait_drained();

        send_gap_pct <= 0;
        recv_stall_pct <= 0;
        fill_phase(ITEMS_PER_PHASE);
        wait_drained();

        // catch any stray result behind the last one
        repeat (8) @(posedge clk);
        if (errors == 0 && track_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hdl/mct_pkg.sv
hdl/mct_front.sv
hdl/mct_queue.sv
hdl/mct_back.sv
hdl/mmc_card_state_tracker.sv
tb/tb_top.sv
